[rtl/nshp_pkg.sv]
// ----------------------------------------------------------------------------
// nshp_pkg
// Shared types and constants of the network information section header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nshp_pkg;

  localparam int PID_W     = 13;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 12;
  localparam int POS_W     = 13;
  localparam int NID_W     = 16;
  localparam int VER_W     = 5;
  localparam int SECNUM_W  = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  // slave tuser: stream_pid, section_start
  localparam int IN_USER_W  = PID_W + 1;
  // master tdata: 73 bits of fields, padded to whole bytes
  localparam int OUT_FIELD_W = LEN_W + NID_W + VER_W + 2 * SECNUM_W + 2 * LEN_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NIT_PID         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_TABLE_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SECTION_LEN = 2'd2;

  // register reset values
  localparam logic [PID_W-1:0]  NIT_PID_RESET       = 13'h0010;
  localparam logic [BYTE_W-1:0] TABLE_ID_RESET      = 8'h40;
  localparam logic [LEN_W-1:0]  MAX_SECTION_LEN_RST = 12'd1024;

  // header byte positions within a section
  localparam logic [POS_W-1:0] POS_TABLE_ID   = 13'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI     = 13'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO     = 13'd2;
  localparam logic [POS_W-1:0] POS_NID_HI     = 13'd3;
  localparam logic [POS_W-1:0] POS_NID_LO     = 13'd4;
  localparam logic [POS_W-1:0] POS_VERSION    = 13'd5;
  localparam logic [POS_W-1:0] POS_SECTION    = 13'd6;
  localparam logic [POS_W-1:0] POS_LAST_SECT  = 13'd7;
  localparam logic [POS_W-1:0] POS_DLOOP_HI   = 13'd8;
  // position of the low length byte, from which the section length counts
  localparam logic [POS_W-1:0] LEN_TAIL_OFFSET = 13'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_DLOOP,
    PH_SLEN_HI,
    PH_SLEN_LO,
    PH_SLOOP,
    PH_TAIL
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW          = 3'd0,
    ST_RESTART      = 3'd1,
    ST_APPENDED     = 3'd2,
    ST_IGNORED      = 3'd3,
    ST_BAD_LENGTH   = 3'd4,
    ST_LOOP_OVERRUN = 3'd5
  } status_t;

  typedef struct packed {
    logic [PID_W-1:0]  nit_pid;
    logic [BYTE_W-1:0] wanted_table_id;
    logic [LEN_W-1:0]  max_section_length;
  } cfg_t;

  typedef struct packed {
    logic [PID_W-1:0]  stream_pid;
    logic              section_start;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [NID_W-1:0]    network_id;
    logic [VER_W-1:0]    version;
    logic [SECNUM_W-1:0] section_number;
    logic [SECNUM_W-1:0] last_section_number;
  } hdr_t;

  typedef struct packed {
    logic [LEN_W-1:0] descriptor;
    logic [LEN_W-1:0] stream;
  } loops_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] section_length;
    hdr_t             hdr;
    loops_t           loops;
  } result_t;

  // handoff from the input register to the parser
  typedef struct packed {
    logic  fire;
    item_t item;
  } stage_t;

endpackage

`default_nettype wire

[rtl/nshp_in_stage.sv]
// ----------------------------------------------------------------------------
// nshp_in_stage
// Input register: holds one byte transfer until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nshp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire nshp_pkg::item_t s_item,
  input  wire logic            out_free,
  output nshp_pkg::stage_t     stage
);
  import nshp_pkg::*;

  logic  valid;
  item_t item;
  logic  advance;

  assign advance  = valid && out_free;
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

  assign stage.fire = advance;
  assign stage.item = item;

endmodule

`default_nettype wire

[rtl/nshp_parser.sv]
// ----------------------------------------------------------------------------
// nshp_parser
// Section state machine: header capture, loop skipping and set tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module nshp_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nshp_pkg::cfg_t   cfg,
  input  wire nshp_pkg::stage_t stage,
  output logic                  res_valid,
  output nshp_pkg::result_t     res
);
  import nshp_pkg::*;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] len_latch, len_next;
  logic [LEN_W-1:0] rem, rem_next;
  hdr_t             hdr, hdr_next;
  loops_t           loops, loops_next;
  logic             present, present_next;
  logic [VER_W-1:0] stored_ver, stored_ver_next;
  logic [SECNUM_W-1:0] stored_sect, stored_sect_next;

  // state as seen by this byte, after a section start has cleared it
  phase_t           ph0;
  logic [POS_W-1:0] pos0;
  logic [LEN_W-1:0] len0, rem0;
  hdr_t             hdr0;
  loops_t           loops0;

  logic   active;
  logic   start;
  logic [BYTE_W-1:0] b;
  phase_t w_phase;
  logic   abort, bad_len, at_end;
  status_t track_status;

  assign b      = stage.item.data_byte;
  assign start  = stage.item.section_start;
  assign active = stage.fire && (stage.item.stream_pid == cfg.nit_pid)
                  && (start || phase != PH_IDLE);

  always_comb begin
    if (start) begin
      ph0    = PH_HDR;
      pos0   = '0;
      len0   = '0;
      rem0   = '0;
      hdr0   = '0;
      loops0 = '0;
    end else begin
      ph0    = phase;
      pos0   = pos;
      len0   = len_latch;
      rem0   = rem;
      hdr0   = hdr;
      loops0 = loops;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pos         <= '0;
      len_latch   <= '0;
      rem         <= '0;
      hdr         <= '0;
      loops       <= '0;
      present     <= 1'b0;
      stored_ver  <= '0;
      stored_sect <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      len_latch   <= len_next;
      rem         <= rem_next;
      hdr         <= hdr_next;
      loops       <= loops_next;
      present     <= present_next;
      stored_ver  <= stored_ver_next;
      stored_sect <= stored_sect_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    len_next         = len_latch;
    rem_next         = rem;
    hdr_next         = hdr;
    loops_next       = loops;
    present_next     = present;
    stored_ver_next  = stored_ver;
    stored_sect_next = stored_sect;
    w_phase          = ph0;
    abort            = 1'b0;
    bad_len          = 1'b0;
    at_end           = 1'b0;
    track_status     = ST_IGNORED;
    res_valid        = 1'b0;
    res.status       = ST_IGNORED;

    if (active) begin
      len_next   = len0;
      rem_next   = rem0;
      hdr_next   = hdr0;
      loops_next = loops0;

      unique case (ph0)
        PH_HDR: begin
          case (pos0)
            POS_TABLE_ID: abort = (b != cfg.wanted_table_id);
            POS_LEN_HI:   len_next = {b[3:0], 8'h00};
            POS_LEN_LO: begin
              len_next = {len0[11:8], b};
              bad_len  = (len_next == '0) || (len_next > cfg.max_section_length);
            end
            POS_NID_HI:    hdr_next.network_id = {b, 8'h00};
            POS_NID_LO:    hdr_next.network_id = {hdr0.network_id[15:8], b};
            POS_VERSION:   hdr_next.version = b[5:1];
            POS_SECTION:   hdr_next.section_number = b;
            POS_LAST_SECT: hdr_next.last_section_number = b;
            POS_DLOOP_HI:  loops_next.descriptor = {b[3:0], 8'h00};
            default: begin
              loops_next.descriptor = {loops0.descriptor[11:8], b};
              rem_next = loops_next.descriptor;
              w_phase  = (rem_next != '0) ? PH_DLOOP : PH_SLEN_HI;
            end
          endcase
        end
        PH_DLOOP: begin
          rem_next = rem0 - 1'b1;
          if (rem_next == '0) w_phase = PH_SLEN_HI;
        end
        PH_SLEN_HI: begin
          loops_next.stream = {b[3:0], 8'h00};
          w_phase = PH_SLEN_LO;
        end
        PH_SLEN_LO: begin
          loops_next.stream = {loops0.stream[11:8], b};
          rem_next = loops_next.stream;
          w_phase  = (rem_next != '0) ? PH_SLOOP : PH_TAIL;
        end
        PH_SLOOP: begin
          rem_next = rem0 - 1'b1;
          if (rem_next == '0) w_phase = PH_TAIL;
        end
        PH_IDLE, PH_TAIL: ;
        default: ;
      endcase

      // last byte of the section: three header bytes plus the length
      at_end = !abort && !bad_len && (pos0 >= POS_LEN_LO)
               && (pos0 == {1'b0, len_next} + LEN_TAIL_OFFSET);

      // set tracking on a section that closed cleanly
      if (!present) begin
        track_status = ST_NEW;
      end else if (stored_ver != hdr_next.version) begin
        track_status = ST_RESTART;
      end else if (stored_sect < hdr_next.section_number
                   && hdr_next.section_number <= hdr_next.last_section_number) begin
        track_status = ST_APPENDED;
      end else begin
        track_status = ST_IGNORED;
      end

      pos_next   = pos0 + 1'b1;
      phase_next = w_phase;

      if (abort) begin
        phase_next = PH_IDLE;
        pos_next   = pos0;
      end else if (bad_len) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res.status = ST_BAD_LENGTH;
      end else if (at_end) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        if (w_phase == PH_TAIL) begin
          res.status = track_status;
          if (track_status != ST_IGNORED) begin
            present_next     = 1'b1;
            stored_ver_next  = hdr_next.version;
            stored_sect_next = hdr_next.section_number;
          end
        end else begin
          res.status = ST_LOOP_OVERRUN;
        end
      end
    end

    res.section_length = len_next;
    res.hdr            = hdr_next;
    res.loops          = loops_next;
  end

endmodule

`default_nettype wire

[rtl/nshp_out_stage.sv]
// ----------------------------------------------------------------------------
// nshp_out_stage
// Result register: holds one header report until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nshp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire nshp_pkg::result_t load_res,
  output logic                   out_free,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output nshp_pkg::result_t      m_res
);
  import nshp_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= load_res;
    end
  end

endmodule

`default_nettype wire

[rtl/nit_section_header_parser_core.sv]
// ----------------------------------------------------------------------------
// nit_section_header_parser_core
// Parses network information sections from a PID-tagged byte stream and
// reports each section header with a table set tracking status.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tdata: data_byte; tuser: stream_pid, section_start
//  m_*       out   m_tvalid/m_tready  tdata: header fields; tuser: status
//  cfg_*     in    cfg_wr_en          cfg_index, cfg_wdata
//
//  one byte per cycle sustained; a byte is parsed while it sits in the input
//  register and its report lands in the result register at the next edge.
//  the result register holds a report while m_tready is low; the input
//  register then holds the next byte and s_tready drops.
//  rst is synchronous and clears the valid flags of both registers and all parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module nit_section_header_parser_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // data_byte[7:0]
  input  wire logic [nshp_pkg::BYTE_W-1:0]          s_tdata,
  // stream_pid[12:0], section_start[13]
  input  wire logic [nshp_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // section_length[11:0], network_id[27:12], version[32:28],
  // section_number[40:33], last_section_number[48:41],
  // descriptor_loop_length[60:49], stream_loop_length[72:61], zero[79:73]
  output logic [nshp_pkg::OUT_DATA_W-1:0]           m_tdata,
  // status[2:0]
  output logic [nshp_pkg::STATUS_W-1:0]             m_tuser,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [nshp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [nshp_pkg::CFG_W-1:0]           cfg_wdata
);
  import nshp_pkg::*;

  cfg_t    cfg;
  item_t   s_item;
  stage_t  stage;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nit_pid            <= NIT_PID_RESET;
      cfg.wanted_table_id    <= TABLE_ID_RESET;
      cfg.max_section_length <= MAX_SECTION_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NIT_PID:         cfg.nit_pid <= cfg_wdata[PID_W-1:0];
        REG_WANTED_TABLE_ID: cfg.wanted_table_id <= cfg_wdata[BYTE_W-1:0];
        REG_MAX_SECTION_LEN: cfg.max_section_length <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_item.stream_pid    = s_tuser[PID_W-1:0];
  assign s_item.section_start = s_tuser[PID_W];
  assign s_item.data_byte     = s_tdata;

  nshp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .out_free (out_free),
    .stage    (stage)
  );

  nshp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stage     (stage),
    .res_valid (res_valid),
    .res       (res)
  );

  nshp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tuser = m_res.status;
  assign m_tdata = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}},
                    m_res.loops.stream,
                    m_res.loops.descriptor,
                    m_res.hdr.last_section_number,
                    m_res.hdr.section_number,
                    m_res.hdr.version,
                    m_res.hdr.network_id,
                    m_res.section_length};

endmodule

`default_nettype wire

[rtl/nshp_checker.sv]
// ----------------------------------------------------------------------------
// nshp_checker
// Port-level checks on the section header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nshp_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_tvalid,
  input wire logic                                 s_tready,
  input wire logic                                 m_tvalid,
  input wire logic                                 m_tready,
  input wire logic [nshp_pkg::OUT_DATA_W-1:0]      m_tdata,
  input wire logic [nshp_pkg::STATUS_W-1:0]        m_tuser
);
  import nshp_pkg::*;

  // a report waiting on the sink keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("report changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_LOOP_OVERRUN))
    else $error("status code out of range");

  // a bad length report carries only the length
  a_bad_len_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_BAD_LENGTH) |-> (m_tdata[OUT_DATA_W-1:LEN_W] == '0))
    else $error("bad length report has header fields");

  // a report with nothing accepted before it cannot appear
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 1)
                        || $past(m_tvalid, 1))
    else $error("report without a preceding byte");

endmodule

bind nit_section_header_parser_core nshp_checker u_nshp_checker (.*);

`default_nettype wire
